// File: design/fmqd_pkg.sv
// Shared types and constants for the FM quadrature discriminator.
package fmqd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int GAIN_W           = 16;
    localparam int OUT_W            = 16;
    localparam int POWER_W          = 32;
    localparam int QUO_W            = 16;
    localparam int QCNT_W           = $clog2(QUO_W);

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [OUT_W-1:0]  POS_LIMIT  = 16'h7FFF;
    localparam logic [OUT_W-1:0]  NEG_LIMIT  = 16'h8000;

    // multiply sequence steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_DQ  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DI  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_II  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_QQ  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ML  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_MH  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FIN = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

endpackage

// File: design/fmqd_mul.sv
// Shared signed multiplier with a registered product.
module fmqd_mul
    import fmqd_pkg::*;
#(
    parameter int A_W = 17,
    parameter int B_W = 17
) (
    input  logic                     i_clk,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// File: design/fmqd_div.sv
// Restoring divider, one quotient bit per step.
module fmqd_div
    import fmqd_pkg::*;
#(
    parameter int DIVISOR_W = 32
) (
    input  logic                          i_clk,
    input  t_div_ctrl                     i_ctrl,
    input  logic [DIVISOR_W+QUO_W-1:0]    i_dividend,
    input  logic [DIVISOR_W-1:0]          i_divisor,
    output logic [QUO_W-1:0]              o_quo
);

    logic [DIVISOR_W-1:0] r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 take;

    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign take  = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= i_dividend[DIVISOR_W+QUO_W-1:QUO_W];
            r_quo <= i_dividend[QUO_W-1:0];
        end else if (i_ctrl.step) begin
            // shift the next dividend bit into the remainder, the quotient bit into r_quo
            r_rem <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], take};
        end
    end

    assign o_quo = r_quo;

endmodule

// File: design/fm_quadrature_discriminator.sv
// FM quadrature discriminator: sequencer, datapath and result register.
// Sequence: an accepted item passes through the shared multiplier steps, an
// overflow check, the divider steps and a load into the result register.
// One item is worked on at a time, set by the single multiplier and the
// one-bit-per-cycle restoring divider; input stall is high while busy.
// Reset (synchronous, active low) clears sample history, sets gain to 1.0.
module fm_quadrature_discriminator
    import fmqd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_phase,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quadrature,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [OUT_W-1:0]        o_demod_out,
    output logic [POWER_W-1:0]             o_power,
    output logic                           o_div_by_zero,
    output logic                           o_saturated,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [GAIN_W-1:0]              i_cfg_data
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int MB    = (W + 1 > GAIN_W + 1) ? W + 1 : GAIN_W + 1;
    localparam int PRW   = W + 1 + MB;
    localparam int NW    = 2 * W + 1;
    localparam int PWW   = 2 * W;
    localparam int BIGW  = PWW + QUO_W;
    localparam int PW_SHR = (2 * W >= POWER_W) ? 2 * W - POWER_W : 0;
    localparam int PW_SHL = (2 * W >= POWER_W) ? 0 : POWER_W - 2 * W;

    t_state r_state, n_state;
    t_div_ctrl div_ctrl;
    logic out_load;
    logic in_acc, out_acc;

    logic [GAIN_W-1:0]       r_gain;
    logic signed [W-1:0]     r_ip1, r_ip2, r_qp1, r_qp2;
    logic signed [W:0]       r_dq, r_di;
    logic [STEP_W-1:0]       r_step;
    logic [QCNT_W-1:0]       r_cnt;
    logic signed [NW-1:0]    r_num;
    logic [PWW-1:0]          r_pw;
    logic [BIGW-1:0]         r_big;
    logic                    r_dz, r_ovf;

    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_demod;
    logic [POWER_W-1:0]      r_o_power;
    logic                    r_o_dz, r_o_sat;

    logic signed [W:0]       mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PRW-1:0]   prod;
    logic [NW-1:0]           num_neg;
    logic [PWW-1:0]          mag;
    logic signed [MB-1:0]    gain_ext;
    logic [QUO_W-1:0]        quo;
    logic                    neg;
    logic [OUT_W-1:0]        limit;
    logic                    clip;
    logic [OUT_W-1:0]        mag_res;
    logic signed [OUT_W-1:0] res;
    logic [POWER_W+PWW-1:0]  pw_wide;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_o_valid && !i_stall;

    assign num_neg  = -r_num;
    assign mag      = r_num[NW-1] ? num_neg[PWW-1:0] : r_num[PWW-1:0];
    assign gain_ext = {{(MB-GAIN_W){1'b0}}, r_gain};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            STEP_DQ: begin
                mul_a = r_dq;
                mul_b = {{(MB-W){r_ip2[W-1]}}, r_ip2};
            end
            STEP_DI: begin
                mul_a = r_di;
                mul_b = {{(MB-W){r_qp2[W-1]}}, r_qp2};
            end
            STEP_II: begin
                mul_a = {r_ip2[W-1], r_ip2};
                mul_b = {{(MB-W){r_ip2[W-1]}}, r_ip2};
            end
            STEP_QQ: begin
                mul_a = {r_qp2[W-1], r_qp2};
                mul_b = {{(MB-W){r_qp2[W-1]}}, r_qp2};
            end
            STEP_ML: begin
                mul_a = {1'b0, mag[W-1:0]};
                mul_b = gain_ext;
            end
            STEP_MH: begin
                mul_a = {1'b0, mag[PWW-1:W]};
                mul_b = gain_ext;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fmqd_mul #(
        .A_W(W + 1),
        .B_W(MB)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    fmqd_div #(
        .DIVISOR_W(PWW)
    ) u_div (
        .i_clk      (i_clk),
        .i_ctrl     (div_ctrl),
        .i_dividend (r_big),
        .i_divisor  (r_pw),
        .o_quo      (quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_MUL;
            S_MUL:  if (r_step == STEP_FIN) n_state = S_CHK;
            S_CHK:  n_state = S_DIV;
            S_DIV:  if (r_cnt == QCNT_W'(QUO_W - 1)) n_state = S_DONE;
            S_DONE: if (!r_o_valid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall       = 1'b1;
        div_ctrl.load = 1'b0;
        div_ctrl.step = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_MUL:  ;
            S_CHK:  div_ctrl.load = 1'b1;
            S_DIV:  div_ctrl.step = 1'b1;
            S_DONE: out_load = !r_o_valid || !i_stall;
            default: o_stall = 1'b1;
        endcase
    end

    // final scaling and saturation
    assign neg     = r_num[NW-1];
    assign limit   = neg ? NEG_LIMIT : POS_LIMIT;
    assign clip    = r_ovf || (quo > limit);
    assign mag_res = clip ? limit : quo;
    assign res     = r_dz ? '0 : (neg ? -mag_res : mag_res);
    assign pw_wide = ({{POWER_W{1'b0}}, r_pw} << PW_SHL) >> PW_SHR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gain    <= GAIN_RESET;
            r_ip1     <= '0;
            r_ip2     <= '0;
            r_qp1     <= '0;
            r_qp2     <= '0;
            r_step    <= STEP_DQ;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            if (in_acc) begin
                // differences use the older history before it shifts
                r_dq   <= {i_quadrature[W-1], i_quadrature} - {r_qp2[W-1], r_qp2};
                r_di   <= {i_in_phase[W-1], i_in_phase} - {r_ip2[W-1], r_ip2};
                r_ip2  <= r_ip1;
                r_ip1  <= i_in_phase;
                r_qp2  <= r_qp1;
                r_qp1  <= i_quadrature;
                r_step <= STEP_DQ;
            end
            if (r_state == S_MUL) begin
                r_step <= r_step + STEP_W'(1);
                case (r_step)
                    STEP_DI:  r_num <= prod[NW-1:0];
                    STEP_II:  r_num <= r_num - prod[NW-1:0];
                    STEP_QQ:  r_pw  <= prod[PWW-1:0];
                    STEP_ML:  r_pw  <= r_pw + prod[PWW-1:0];
                    STEP_MH:  r_big <= BIGW'(prod[W+GAIN_W-1:0]);
                    STEP_FIN: r_big <= r_big + {prod[W+GAIN_W-1:0], {W{1'b0}}};
                    default:  ;
                endcase
            end
            if (r_state == S_CHK) begin
                r_dz  <= (r_pw == '0);
                r_ovf <= (r_big[BIGW-1:QUO_W] >= r_pw);
                r_cnt <= '0;
            end
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_demod <= res;
            r_o_power <= pw_wide[POWER_W-1:0];
            r_o_dz    <= r_dz;
            r_o_sat   <= !r_dz && clip;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_demod_out   = r_o_demod;
    assign o_power       = r_o_power;
    assign o_div_by_zero = r_o_dz;
    assign o_saturated   = r_o_sat;
    assign o_cfg_ready   = 1'b1;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a computation was starting");

    a_zero_power_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_by_zero) |-> (o_demod_out == '0 && !o_saturated))
        else $error("zero power item carries a nonzero result");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        (o_demod_out == signed'(POS_LIMIT) || o_demod_out == signed'(NEG_LIMIT)))
        else $error("saturated item not at a range limit");

endmodule
